@@ rtl/mbsa_pkg.sv @@
// Shared types and constants for the multi-block stack allocator.
package mbsa_pkg;

   localparam int BLOCK_BYTES     = 4096;
   localparam int MAX_BLOCKS      = 16;
   localparam int NODES_PER_BLOCK = 64;
   localparam int HEADER_BYTES    = 8;

   localparam int BLK_W   = 4;
   localparam int NODE_W  = 6;
   localparam int CNT_W   = 7;
   localparam int OPEN_W  = 5;
   localparam int TOP_W   = 13;
   localparam int SIZE_W  = 13;
   localparam int ARITH_W = 15;
   localparam int SLOT_W  = BLK_W + NODE_W;
   localparam int SLOTS   = MAX_BLOCKS * NODES_PER_BLOCK;
   localparam int ENTRY_W = TOP_W + SIZE_W + 1;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_NOROOM = 2'd1;
   localparam logic [1:0] STATUS_BADFREE = 2'd2;

   localparam logic CSR_ALIGN_ENABLE = 1'b0;
   localparam logic CSR_ALIGN_LOG2   = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_SCAN     = 7'b0000010,
      ST_FREE_RD  = 7'b0000100,
      ST_FREE_CHK = 7'b0001000,
      ST_POP_RD   = 7'b0010000,
      ST_POP_CHK  = 7'b0100000,
      ST_DONE     = 7'b1000000
   } state_type;

   typedef struct packed {
      logic [ARITH_W-1:0] start;
      logic               fits;
   } fit_type;

   typedef struct packed {
      logic [TOP_W-1:0]  start;
      logic [SIZE_W-1:0] bytes;
      logic              live;
   } entry_type;

endpackage

@@ rtl/multi_block_stack_allocator.sv @@
// Multi-block stack allocator: sequencer, block table and node store.
//
//  channel | ports                        | direction
//  req     | req_valid/req_stall + fields | in
//  rsp     | rsp_valid/rsp_stall + fields | out
//  csr     | csr_write/index/data         | in
//
// Allocate: blocks are scanned one after another through the shared fit unit,
// then the result is handed over; free: the node is read and checked, then dead
// nodes are popped off the top until a live node stops the pop or the block is
// empty, before the same handover; a bad handle goes straight to the handover.
// Reset clears the block counts and totals; the node store needs no clearing.
// req_stall is high while a request is in work; a finished result waits in the
// output register while rsp_stall holds it.
module multi_block_stack_allocator
   import mbsa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_opcode,
   input  logic [12:0]       req_alloc_size,
   input  logic [3:0]        req_free_block,
   input  logic [5:0]        req_free_node,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [3:0]        rsp_block_index,
   output logic [5:0]        rsp_node_index,
   output logic [11:0]       rsp_byte_offset,
   output logic [4:0]        rsp_nonempty_blocks,
   output logic [16:0]       rsp_allocated_bytes,
   output logic [10:0]       rsp_allocated_count,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [2:0]        csr_data
);

   state_type state_ff, state_in;

   logic              align_en_ff, align_en_in;
   logic [2:0]        align_log2_ff, align_log2_in;

   logic [TOP_W-1:0]  top_ff [MAX_BLOCKS];
   logic [TOP_W-1:0]  top_in [MAX_BLOCKS];
   logic [CNT_W-1:0]  count_ff [MAX_BLOCKS];
   logic [CNT_W-1:0]  count_in [MAX_BLOCKS];

   logic [BLK_W-1:0]  current_ff, current_in;
   logic [OPEN_W-1:0] open_ff, open_in;
   logic [OPEN_W-1:0] nonempty_ff, nonempty_in;
   logic [16:0]       total_bytes_ff, total_bytes_in;
   logic [10:0]       total_count_ff, total_count_in;

   logic [SIZE_W-1:0] size_ff, size_in;
   logic [BLK_W-1:0]  fb_ff, fb_in;
   logic [NODE_W-1:0] fn_ff, fn_in;
   logic [OPEN_W-1:0] b_ff, b_in;

   logic [1:0]        res_status_ff, res_status_in;
   logic [BLK_W-1:0]  res_block_ff, res_block_in;
   logic [NODE_W-1:0] res_node_ff, res_node_in;
   logic [11:0]       res_off_ff, res_off_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [3:0]        rsp_block_ff, rsp_block_in;
   logic [5:0]        rsp_node_ff, rsp_node_in;
   logic [11:0]       rsp_off_ff, rsp_off_in;
   logic [4:0]        rsp_nonempty_ff, rsp_nonempty_in;
   logic [16:0]       rsp_bytes_ff, rsp_bytes_in;
   logic [10:0]       rsp_count_ff, rsp_count_in;

   fit_type           fit;
   logic              ram_we;
   logic [SLOT_W-1:0] ram_waddr;
   entry_type         ram_wdata;
   logic [SLOT_W-1:0] ram_raddr;
   entry_type         ram_rdata;
   logic [CNT_W-1:0]  fb_count;
   logic [CNT_W-1:0]  fb_count_dec;
   logic              cand;
   logic              extra;

   assign fb_count     = count_ff[fb_ff];
   assign fb_count_dec = fb_count - CNT_W'(1);

   mbsa_fit u_fit (
      .top            (top_ff[b_ff[BLK_W-1:0]]),
      .count          (count_ff[b_ff[BLK_W-1:0]]),
      .size           (size_ff),
      .align_enable   (align_en_ff),
      .alignment_log2 (align_log2_ff),
      .fit            (fit)
   );

   mbsa_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_nodes (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      ram_raddr = (state_ff == ST_FREE_RD) ? {fb_ff, fn_ff}
                                           : {fb_ff, fb_count_dec[NODE_W-1:0]};
   end

   always_comb begin
      state_in       = state_ff;
      align_en_in    = align_en_ff;
      align_log2_in  = align_log2_ff;
      top_in         = top_ff;
      count_in       = count_ff;
      current_in     = current_ff;
      open_in        = open_ff;
      nonempty_in    = nonempty_ff;
      total_bytes_in = total_bytes_ff;
      total_count_in = total_count_ff;
      size_in        = size_ff;
      fb_in          = fb_ff;
      fn_in          = fn_ff;
      b_in           = b_ff;
      res_status_in  = res_status_ff;
      res_block_in   = res_block_ff;
      res_node_in    = res_node_ff;
      res_off_in     = res_off_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_block_in   = rsp_block_ff;
      rsp_node_in    = rsp_node_ff;
      rsp_off_in     = rsp_off_ff;
      rsp_nonempty_in = rsp_nonempty_ff;
      rsp_bytes_in   = rsp_bytes_ff;
      rsp_count_in   = rsp_count_ff;
      ram_we         = 1'b0;
      ram_waddr      = {fb_ff, fn_ff};
      ram_wdata      = ram_rdata;
      cand           = b_ff < open_ff;
      extra          = (b_ff == open_ff) && (open_ff < OPEN_W'(MAX_BLOCKS));

      if (csr_write) begin
         case (csr_index)
            CSR_ALIGN_ENABLE: align_en_in   = csr_data[0];
            CSR_ALIGN_LOG2:   align_log2_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               size_in       = req_alloc_size;
               fb_in         = req_free_block;
               fn_in         = req_free_node;
               b_in          = {1'b0, current_ff};
               res_status_in = STATUS_OK;
               res_block_in  = '0;
               res_node_in   = '0;
               res_off_in    = '0;
               state_in      = (req_opcode == OP_FREE) ? ST_FREE_RD : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if ((cand || extra) && fit.fits) begin
               ram_we          = 1'b1;
               ram_waddr       = {b_ff[BLK_W-1:0], count_ff[b_ff[BLK_W-1:0]][NODE_W-1:0]};
               ram_wdata.start = fit.start[TOP_W-1:0];
               ram_wdata.bytes = size_ff;
               ram_wdata.live  = 1'b1;
               count_in[b_ff[BLK_W-1:0]] = count_ff[b_ff[BLK_W-1:0]] + CNT_W'(1);
               top_in[b_ff[BLK_W-1:0]]   = fit.start[TOP_W-1:0] + size_ff
                                           + TOP_W'(HEADER_BYTES);
               if (count_ff[b_ff[BLK_W-1:0]] == '0) begin
                  nonempty_in = nonempty_ff + OPEN_W'(1);
               end
               if (extra) begin
                  open_in = open_ff + OPEN_W'(1);
               end
               total_bytes_in = total_bytes_ff + 17'(size_ff);
               total_count_in = total_count_ff + 11'(1);
               current_in     = b_ff[BLK_W-1:0];
               res_block_in   = b_ff[BLK_W-1:0];
               res_node_in    = count_ff[b_ff[BLK_W-1:0]][NODE_W-1:0];
               res_off_in     = fit.start[11:0];
               state_in       = ST_DONE;
            end else if (cand) begin
               b_in = b_ff + OPEN_W'(1);
            end else begin
               res_status_in = STATUS_NOROOM;
               state_in      = ST_DONE;
            end
         end
         ST_FREE_RD: begin
            // node entry is on its way out of the store
            if (({1'b0, fb_ff} >= open_ff) || ({1'b0, fn_ff} >= fb_count)) begin
               res_status_in = STATUS_BADFREE;
               state_in      = ST_DONE;
            end else begin
               state_in = ST_FREE_CHK;
            end
         end
         ST_FREE_CHK: begin
            if (!ram_rdata.live) begin
               res_status_in = STATUS_BADFREE;
               state_in      = ST_DONE;
            end else begin
               ram_we         = 1'b1;
               ram_wdata.live = 1'b0;
               state_in       = ST_POP_RD;
            end
         end
         ST_POP_RD: begin
            if (fb_count == '0) begin
               current_in = fb_ff;
               state_in   = ST_DONE;
            end else begin
               state_in = ST_POP_CHK;
            end
         end
         ST_POP_CHK: begin
            if (ram_rdata.live) begin
               state_in = ST_DONE;
            end else begin
               // drop the dead top node and fall back to its start
               count_in[fb_ff] = fb_count_dec;
               top_in[fb_ff]   = ram_rdata.start;
               total_count_in  = total_count_ff - 11'(1);
               total_bytes_in  = total_bytes_ff - 17'(ram_rdata.bytes);
               if (fb_count == CNT_W'(1)) begin
                  nonempty_in = nonempty_ff - OPEN_W'(1);
               end
               state_in = ST_POP_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = res_status_ff;
               rsp_block_in    = res_block_ff;
               rsp_node_in     = res_node_ff;
               rsp_off_in      = res_off_ff;
               rsp_nonempty_in = nonempty_ff;
               rsp_bytes_in    = total_bytes_ff;
               rsp_count_in    = total_count_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         align_en_ff    <= 1'b0;
         align_log2_ff  <= 3'd3;
         count_ff       <= '{default: '0};
         current_ff     <= '0;
         open_ff        <= OPEN_W'(1);
         nonempty_ff    <= '0;
         total_bytes_ff <= '0;
         total_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         align_en_ff    <= align_en_in;
         align_log2_ff  <= align_log2_in;
         count_ff       <= count_in;
         current_ff     <= current_in;
         open_ff        <= open_in;
         nonempty_ff    <= nonempty_in;
         total_bytes_ff <= total_bytes_in;
         total_count_ff <= total_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      top_ff          <= top_in;
      size_ff         <= size_in;
      fb_ff           <= fb_in;
      fn_ff           <= fn_in;
      b_ff            <= b_in;
      res_status_ff   <= res_status_in;
      res_block_ff    <= res_block_in;
      res_node_ff     <= res_node_in;
      res_off_ff      <= res_off_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_block_ff    <= rsp_block_in;
      rsp_node_ff     <= rsp_node_in;
      rsp_off_ff      <= rsp_off_in;
      rsp_nonempty_ff <= rsp_nonempty_in;
      rsp_bytes_ff    <= rsp_bytes_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_block_index     = rsp_block_ff;
   assign rsp_node_index      = rsp_node_ff;
   assign rsp_byte_offset     = rsp_off_ff;
   assign rsp_nonempty_blocks = rsp_nonempty_ff;
   assign rsp_allocated_bytes = rsp_bytes_ff;
   assign rsp_allocated_count = rsp_count_ff;

   a_nonempty_le_open: assert property (@(posedge clock) disable iff (reset)
      nonempty_ff <= open_ff)
      else $error("more nonempty blocks than open blocks");

   a_current_open: assert property (@(posedge clock) disable iff (reset)
      {1'b0, current_ff} < open_ff)
      else $error("current block is not open");

   a_empty_totals: assert property (@(posedge clock) disable iff (reset)
      (total_count_ff == '0) |-> (total_bytes_ff == '0) && (nonempty_ff == '0))
      else $error("bytes or blocks held with no nodes");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (b_ff <= open_ff))
      else $error("scan ran past the open blocks");

endmodule

@@ rtl/mbsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mbsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/mbsa_fit.sv @@
// Start offset and fit test for one candidate block.
module mbsa_fit
   import mbsa_pkg::*;
(
   input  logic [TOP_W-1:0]  top,
   input  logic [CNT_W-1:0]  count,
   input  logic [SIZE_W-1:0] size,
   input  logic              align_enable,
   input  logic [2:0]        alignment_log2,
   output fit_type           fit
);

   logic               empty;
   logic [ARITH_W-1:0] x;
   logic [ARITH_W-1:0] sum;
   logic [ARITH_W-1:0] aligned;
   logic [ARITH_W-1:0] start;
   logic [ARITH_W-1:0] stop;

   always_comb begin
      empty = (count == '0);
      x     = empty ? '0 : ARITH_W'(top);
      // smallest multiple of the alignment at or above x + header, never x itself
      sum     = x + ARITH_W'(HEADER_BYTES - 1);
      aligned = ((sum >> alignment_log2) + ARITH_W'(1)) << alignment_log2;
      if (align_enable) begin
         start = aligned;
      end else begin
         start = empty ? ARITH_W'(HEADER_BYTES) : x;
      end
      stop      = start + ARITH_W'(size);
      fit.start = start;
      fit.fits  = (stop < ARITH_W'(BLOCK_BYTES)) && (count < CNT_W'(NODES_PER_BLOCK));
   end

endmodule
